FILE: src/cfd_pkg.sv
package cfd_pkg;

	localparam int MAX_PIXELS = 1048576;
	localparam int CNT_W = 21;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int CNT_CAP_I = (MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

	localparam int Q_W = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_DARK_LEVEL      = 2'd0,
		REG_GAP_MIN         = 2'd1,
		REG_PIXEL_SAT_MIN   = 2'd2,
		REG_FRAME_RATIO_MIN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pix_t;

	typedef struct packed {
		logic             is_color;
		logic [CNT_W-1:0] kept_count;
		logic [CNT_W-1:0] colored_count;
	} res_t;

	typedef struct packed {
		logic [7:0]     dark_level;
		logic [7:0]     gap_min;
		logic [Q_W-1:0] pixel_sat_min;
		logic [Q_W-1:0] frame_ratio_min;
	} cfg_t;

	// Classified pixel handed from the front to the back.
	typedef struct packed {
		logic kept;
		logic colored;
		logic last;
	} cls_t;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return (c < CNT_CAP) ? c + CNT_W'(1) : CNT_CAP;
	endfunction

endpackage

FILE: src/cfd_front.sv
module cfd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  cfd_pkg::cfg_t  cfg,
	input  cfd_pkg::pix_t  pix,
	input  logic           pix_valid,
	output logic           pix_ready,
	output cfd_pkg::cls_t  cls,
	output logic           cls_valid,
	input  logic           cls_ready
);
	import cfd_pkg::*;

	logic [7:0]  mx, mn, mx_rg, mn_rg, spread;
	logic [24:0] spread_sh, sat_prod;
	logic        kept, colored;
	cls_t        cls_s1;
	logic        valid_s1;

	always_comb begin
		mx_rg = (pix.red > pix.green) ? pix.red : pix.green;
		mn_rg = (pix.red < pix.green) ? pix.red : pix.green;
		mx = (pix.blue > mx_rg) ? pix.blue : mx_rg;
		mn = (pix.blue < mn_rg) ? pix.blue : mn_rg;
		spread = mx - mn;
		// Saturation test without division: spread * 2^16 > sat_min * max.
		spread_sh = {1'b0, spread, 16'd0};
		sat_prod = 25'(cfg.pixel_sat_min) * 25'(mx);
		kept = (mx >= cfg.dark_level);
		colored = kept && (spread > cfg.gap_min) && (spread_sh > sat_prod);
	end

	assign pix_ready = !valid_s1 || cls_ready;
	assign cls = cls_s1;
	assign cls_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			cls_s1 <= '{kept: kept, colored: colored, last: pix.frame_end};
		end
	end

endmodule

FILE: src/cfd_queue.sv
module cfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cfd_pkg::cls_t  wr_data,
	input  logic           wr_valid,
	output logic           wr_ready,
	output cfd_pkg::cls_t  rd_data,
	output logic           rd_valid,
	input  logic           rd_ready
);
	import cfd_pkg::*;

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign wr_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/cfd_back.sv
module cfd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cfd_pkg::cfg_t  cfg,
	input  cfd_pkg::cls_t  cls,
	input  logic           cls_valid,
	output logic           cls_ready,
	output cfd_pkg::res_t  res,
	output logic           res_valid,
	input  logic           res_ready
);
	import cfd_pkg::*;

	logic [CNT_W-1:0] kept_q, colored_q, kept_nx, colored_nx;
	logic [CNT_W-1:0] fin_kept_s1, fin_colored_s1;
	logic             fin_valid_s1;
	res_t             res_q;
	logic             res_valid_q;
	logic             fin_go, s1_free, pop;
	logic [37:0]      col_sh, ratio_prod;
	logic             is_color;

	assign fin_go = !res_valid_q || res_ready;
	assign s1_free = !fin_valid_s1 || fin_go;
	// Pixels inside a frame keep flowing while a result waits; only the
	// frame end has to wait for room in the final-count stage.
	assign cls_ready = !cls.last || s1_free;
	assign pop = cls_valid && cls_ready;

	always_comb begin
		kept_nx = cls.kept ? count_up(kept_q) : kept_q;
		colored_nx = cls.colored ? count_up(colored_q) : colored_q;
		col_sh = {1'b0, fin_colored_s1, 16'd0};
		ratio_prod = 38'(cfg.frame_ratio_min) * 38'(fin_kept_s1);
		is_color = (fin_kept_s1 != '0) && (col_sh > ratio_prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			colored_q <= '0;
			fin_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (cls.last) begin
					kept_q <= '0;
					colored_q <= '0;
				end else begin
					kept_q <= kept_nx;
					colored_q <= colored_nx;
				end
			end
			if (s1_free) begin
				fin_valid_s1 <= pop && cls.last;
			end
			if (fin_go) begin
				res_valid_q <= fin_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop && cls.last) begin
			fin_kept_s1 <= kept_nx;
			fin_colored_s1 <= colored_nx;
		end
		if (fin_go && fin_valid_s1) begin
			res_q <= '{is_color: is_color, kept_count: fin_kept_s1,
				colored_count: fin_colored_s1};
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

endmodule

FILE: src/color_frame_detector_unit.sv
// Pixel throughput: one item per cycle while pix_ready is high, set by the
// classify stage and a counter update per cycle in the back end; a frame end
// waits in the queue while the final-count and result registers are full.
// Path of a frame-end item: classify register, queue, final-count register
// and result register, where the result is held until res_ready takes it.
// Reset: arst_n clears the counters, the queue and all valid flags at once;
// the registers return to their default thresholds.
module color_frame_detector_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  cfd_pkg::pix_t               pix,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	output cfd_pkg::res_t               res,
	output logic                        res_valid,
	input  logic                        res_ready
);
	import cfd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	cls_t     f_cls, b_cls;
	logic     f_valid, f_ready, b_valid, b_ready;

	assign pready = 1'b1;
	// Byte lanes are ignored; registers are decoded by word.
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_level <= 8'd30;
			cfg_q.gap_min <= 8'd20;
			cfg_q.pixel_sat_min <= Q_W'(13107);
			cfg_q.frame_ratio_min <= Q_W'(6554);
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_DARK_LEVEL:      cfg_q.dark_level <= pwdata[7:0];
				REG_GAP_MIN:         cfg_q.gap_min <= pwdata[7:0];
				REG_PIXEL_SAT_MIN:   cfg_q.pixel_sat_min <= pwdata[Q_W-1:0];
				REG_FRAME_RATIO_MIN: cfg_q.frame_ratio_min <= pwdata[Q_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DARK_LEVEL:      prdata = {24'd0, cfg_q.dark_level};
			REG_GAP_MIN:         prdata = {24'd0, cfg_q.gap_min};
			REG_PIXEL_SAT_MIN:   prdata = {{(32-Q_W){1'b0}}, cfg_q.pixel_sat_min};
			REG_FRAME_RATIO_MIN: prdata = {{(32-Q_W){1'b0}}, cfg_q.frame_ratio_min};
			default:             prdata = '0;
		endcase
	end

	cfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.cls       (f_cls),
		.cls_valid (f_valid),
		.cls_ready (f_ready)
	);

	cfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_cls),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (b_cls),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	cfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls       (b_cls),
		.cls_valid (b_valid),
		.cls_ready (b_ready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

endmodule
